// ===== design/wcia_pkg.sv =====
// wcia_pkg: shared types, widths and constants for the wifi channel interference analyzer
// no dependencies; imported by the top level, the serial divider and the port checker
package wcia_pkg;

  // default values of the top level parameters
  localparam int NUM_CHANNELS_DEF = 13;
  localparam int MAX_AP_COUNT_DEF = 255;

  // field and store widths
  localparam int MODE_W    = 1;
  localparam int IN_CH_W   = 8;
  localparam int CH_W      = 4;
  localparam int RSSI_W    = 8;
  localparam int COUNT_W   = 8;
  localparam int SUM_W     = 16;
  localparam int SCORE_W   = 15;
  localparam int PCT_W     = 7;
  localparam int INC_W     = 9;
  localparam int CFG_IDX_W = 2;

  // serial divider widths
  localparam int DIV_W  = 16;
  localparam int DIVR_W = 8;

  // shift-add multiplier step count
  localparam int MUL_CNT_W = $clog2(PCT_W);
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(PCT_W - 1);

  // input modes
  localparam logic [MODE_W-1:0] MODE_RECORD = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FINISH = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADJ_PCT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEC_PCT = 2'd1;

  // register reset values
  localparam logic [PCT_W-1:0] ADJ_PCT_RST = 7'd70;
  localparam logic [PCT_W-1:0] SEC_PCT_RST = 7'd30;

  // arithmetic constants
  localparam logic [DIVR_W-1:0]        PCT_FULL    = 8'd100;
  localparam logic signed [RSSI_W-1:0] FLOOR_RSSI  = -8'sd100;
  localparam logic signed [RSSI_W:0]   WEIGHT_BASE = 9'sd100;
  localparam logic signed [RSSI_W:0]   WEIGHT_MIN  = 9'sd1;

  // favored channels, checked first for the recommendation
  localparam logic [CH_W-1:0] FAV_A = 4'd1;
  localparam logic [CH_W-1:0] FAV_B = 4'd6;
  localparam logic [CH_W-1:0] FAV_C = 4'd11;

  // input transaction
  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [IN_CH_W-1:0]        channel;
    logic signed [RSSI_W-1:0]  rssi;
  } in_item_t;

  // result transaction, one report row
  typedef struct packed {
    logic [CH_W-1:0]           channel_number;
    logic [COUNT_W-1:0]        ap_count;
    logic signed [RSSI_W-1:0]  strongest_rssi;
    logic signed [RSSI_W-1:0]  average_rssi;
    logic [SCORE_W-1:0]        interference_score;
    logic [CH_W-1:0]           best_channel;
    logic                      overflow;
    logic                      last;
  } out_item_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_ADJ,
    ST_WAIT_ADJ,
    ST_DIV_SEC,
    ST_WAIT_SEC,
    ST_UPDATE,
    ST_BEST,
    ST_AVG,
    ST_WAIT_AVG,
    ST_EMIT
  } state_t;

endpackage

// ===== design/wcia_sdiv.sv =====
// wcia_sdiv: bit-serial restoring divider, one quotient bit per cycle
// depends on wcia_pkg for widths and the request/response structs
module wcia_sdiv (
  input  logic               clk,
  input  logic               rst_n,
  input  wcia_pkg::div_req_t req,
  output wcia_pkg::div_rsp_t rsp
);
  import wcia_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [DIVR_W-1:0] den_r, den_nxt;
  logic [DIVR_W:0]   rem_sh;
  logic [DIVR_W:0]   rem_diff;
  logic              fits;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh   = {rem_r, quo_r[DIV_W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    fits     = rem_sh >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_W - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      rem_nxt = fits ? rem_diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== design/wifi_channel_interference_analyzer_top.sv =====
// A counted record runs 7 shift-add steps, two 16-bit serial divisions by 100 and one
// store update; an ignored or dropped record leaves the controller idle. A finish
// transaction runs the best-channel scan, then emits one row per channel, each after a
// 16-bit serial division for the average (none for an empty channel), waiting out any
// output stall. Input is stalled unless idle, so one transaction is handled at a time.
// Reset (synchronous, rst_n low) clears the channel store at once and restores 70/30 percent.
module wifi_channel_interference_analyzer_top #(
  parameter int NUM_CHANNELS = wcia_pkg::NUM_CHANNELS_DEF,
  parameter int MAX_AP_COUNT = wcia_pkg::MAX_AP_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  wcia_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output wcia_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wcia_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wcia_pkg::PCT_W-1:0]       cfg_data
);
  import wcia_pkg::*;

  localparam logic [CH_W-1:0]    LAST_CH   = CH_W'(NUM_CHANNELS);
  localparam logic [IN_CH_W-1:0] TOP_CH_IN = IN_CH_W'(NUM_CHANNELS);
  localparam logic [COUNT_W-1:0] AP_LIMIT  = COUNT_W'(MAX_AP_COUNT);

  state_t state_r, state_nxt;

  // configuration registers
  logic [PCT_W-1:0] adj_pct_r, sec_pct_r;

  // channel store
  logic [COUNT_W-1:0]        count_r     [1:NUM_CHANNELS];
  logic signed [RSSI_W-1:0]  strongest_r [1:NUM_CHANNELS];
  logic signed [SUM_W-1:0]   sum_r       [1:NUM_CHANNELS];
  logic [SCORE_W-1:0]        score_r     [1:NUM_CHANNELS];
  logic [SCORE_W-1:0]        score_upd   [1:NUM_CHANNELS];
  logic                      is_own      [1:NUM_CHANNELS];
  logic [COUNT_W-1:0]        taken_r;
  logic                      dropped_r;

  // record working registers
  logic [CH_W-1:0]           ch_r;
  logic signed [RSSI_W-1:0]  rssi_r;
  logic [RSSI_W-1:0]         w_r;
  logic [SCORE_W-1:0]        mcand_r, acc_a_r, acc_s_r;
  logic [PCT_W-1:0]          pa_sh_r, ps_sh_r;
  logic [MUL_CNT_W-1:0]      mul_cnt_r;
  logic [INC_W-1:0]          inc_a_r, inc_s_r;

  // report working registers
  logic [CH_W-1:0]           idx_r;
  logic [SCORE_W-1:0]        best_score_r;
  logic [CH_W-1:0]           best_ch_r;
  logic                      avg_neg_r;
  logic signed [RSSI_W-1:0]  avg_r;

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                      in_acc, rec_room, ch_ok, take_rec, start_mul, start_rep;
  logic                      out_free, emit_load, clear_store;
  logic signed [RSSI_W:0]    w_ext;
  logic [RSSI_W-1:0]         w_sel;
  logic [SCORE_W-1:0]        fav_score;
  logic [CH_W-1:0]           fav_ch;
  logic signed [SUM_W-1:0]   sum_sel;
  logic [DIV_W-1:0]          sum_mag;
  logic [RSSI_W-1:0]         quo8;

  wcia_sdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // input side decode
  always_comb begin
    in_acc    = in_valid && !in_stall;
    rec_room  = taken_r < AP_LIMIT;
    ch_ok     = in_data.channel inside {[8'd1 : TOP_CH_IN]};
    take_rec  = in_acc && (in_data.mode == MODE_RECORD);
    start_mul = take_rec && rec_room && ch_ok;
    start_rep = in_acc && (in_data.mode == MODE_FINISH);
    w_ext     = WEIGHT_BASE + (RSSI_W + 1)'(in_data.rssi);
    w_sel     = (w_ext < WEIGHT_MIN) ? RSSI_W'(1) : w_ext[RSSI_W-1:0];
  end

  // favored channel pick, lowest score with the first one winning ties
  always_comb begin
    fav_score = score_r[FAV_A];
    fav_ch    = FAV_A;
    if (score_r[FAV_B] < fav_score) begin
      fav_score = score_r[FAV_B];
      fav_ch    = FAV_B;
    end
    if (score_r[FAV_C] < fav_score) begin
      fav_score = score_r[FAV_C];
      fav_ch    = FAV_C;
    end
  end

  // magnitude of the walked channel's sum for the average
  always_comb begin
    sum_sel = sum_r[idx_r];
    sum_mag = sum_sel[SUM_W-1] ? DIV_W'(-sum_sel) : DIV_W'(sum_sel);
    quo8    = div_rsp.quotient[RSSI_W-1:0];
  end

  // controller
  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = PCT_FULL;
    out_free         = !out_valid_r || !out_stall;
    emit_load        = 1'b0;
    clear_store      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start_rep) begin
          state_nxt = ST_BEST;
        end else if (start_mul) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_cnt_r == MUL_LAST) begin
          state_nxt = ST_DIV_ADJ;
        end
      end
      ST_DIV_ADJ: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(acc_a_r);
        state_nxt        = ST_WAIT_ADJ;
      end
      ST_WAIT_ADJ: begin
        if (div_rsp.done) begin
          state_nxt = ST_DIV_SEC;
        end
      end
      ST_DIV_SEC: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(acc_s_r);
        state_nxt        = ST_WAIT_SEC;
      end
      ST_WAIT_SEC: begin
        if (div_rsp.done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
      end
      ST_BEST: begin
        if (idx_r == LAST_CH) begin
          state_nxt = ST_AVG;
        end
      end
      ST_AVG: begin
        if (count_r[idx_r] == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = sum_mag;
          div_req.divisor  = DIVR_W'(count_r[idx_r]);
          state_nxt        = ST_WAIT_AVG;
        end
      end
      ST_WAIT_AVG: begin
        if (div_rsp.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit_load = 1'b1;
          if (idx_r == LAST_CH) begin
            clear_store = 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            state_nxt = ST_AVG;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // per-channel lanes: score increment by distance to the record's channel, saturating
  always_comb begin
    for (int t = 1; t <= NUM_CHANNELS; t++) begin
      logic                d1, d2;
      logic [INC_W-1:0]    inc;
      logic [SCORE_W:0]    sum_s;
      is_own[t] = {1'b0, ch_r} == 5'(t);
      d1 = ({1'b0, ch_r} == 5'(t + 1)) || ({1'b0, ch_r} + 5'd1 == 5'(t));
      d2 = ({1'b0, ch_r} == 5'(t + 2)) || ({1'b0, ch_r} + 5'd2 == 5'(t));
      inc = is_own[t] ? INC_W'(w_r) : (d1 ? inc_a_r : (d2 ? inc_s_r : '0));
      sum_s = {1'b0, score_r[t]} + (SCORE_W + 1)'(inc);
      score_upd[t] = sum_s[SCORE_W] ? '1 : sum_s[SCORE_W-1:0];
    end
  end

  // state register and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      adj_pct_r <= ADJ_PCT_RST;
      sec_pct_r <= SEC_PCT_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ADJ_PCT: adj_pct_r <= cfg_data;
          REG_SEC_PCT: sec_pct_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // channel store, cleared by reset and after the last report row
  always_ff @(posedge clk) begin
    if (!rst_n || clear_store) begin
      for (int t = 1; t <= NUM_CHANNELS; t++) begin
        count_r[t]     <= '0;
        strongest_r[t] <= FLOOR_RSSI;
        sum_r[t]       <= '0;
        score_r[t]     <= '0;
      end
      taken_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      if (take_rec) begin
        if (rec_room) begin
          taken_r <= taken_r + COUNT_W'(1);
        end else begin
          dropped_r <= 1'b1;
        end
      end
      if (state_r == ST_UPDATE) begin
        for (int t = 1; t <= NUM_CHANNELS; t++) begin
          score_r[t] <= score_upd[t];
          if (is_own[t]) begin
            count_r[t] <= count_r[t] + COUNT_W'(1);
            sum_r[t]   <= sum_r[t] + SUM_W'(rssi_r);
            if (rssi_r > strongest_r[t]) begin
              strongest_r[t] <= rssi_r;
            end
          end
        end
      end
    end
  end

  // record datapath: capture, shift-add multiply, quotient capture
  always_ff @(posedge clk) begin
    if (start_mul) begin
      ch_r      <= in_data.channel[CH_W-1:0];
      rssi_r    <= in_data.rssi;
      w_r       <= w_sel;
      mcand_r   <= SCORE_W'(w_sel);
      pa_sh_r   <= adj_pct_r;
      ps_sh_r   <= sec_pct_r;
      acc_a_r   <= '0;
      acc_s_r   <= '0;
      mul_cnt_r <= '0;
    end else if (state_r == ST_MUL) begin
      if (pa_sh_r[0]) begin
        acc_a_r <= acc_a_r + mcand_r;
      end
      if (ps_sh_r[0]) begin
        acc_s_r <= acc_s_r + mcand_r;
      end
      mcand_r   <= {mcand_r[SCORE_W-2:0], 1'b0};
      pa_sh_r   <= {1'b0, pa_sh_r[PCT_W-1:1]};
      ps_sh_r   <= {1'b0, ps_sh_r[PCT_W-1:1]};
      mul_cnt_r <= mul_cnt_r + MUL_CNT_W'(1);
    end
    if (state_r == ST_WAIT_ADJ && div_rsp.done) begin
      inc_a_r <= div_rsp.quotient[INC_W-1:0];
    end
    if (state_r == ST_WAIT_SEC && div_rsp.done) begin
      inc_s_r <= div_rsp.quotient[INC_W-1:0];
    end
  end

  // report datapath: best-channel scan, average, channel walk
  always_ff @(posedge clk) begin
    if (start_rep) begin
      idx_r        <= CH_W'(1);
      best_score_r <= fav_score;
      best_ch_r    <= fav_ch;
    end else if (state_r == ST_BEST) begin
      if (score_r[idx_r] < best_score_r) begin
        best_score_r <= score_r[idx_r];
        best_ch_r    <= idx_r;
      end
      idx_r <= (idx_r == LAST_CH) ? CH_W'(1) : idx_r + CH_W'(1);
    end else if (emit_load && idx_r != LAST_CH) begin
      idx_r <= idx_r + CH_W'(1);
    end
    if (state_r == ST_AVG) begin
      avg_neg_r <= sum_sel[SUM_W-1];
      avg_r     <= FLOOR_RSSI;
    end
    if (state_r == ST_WAIT_AVG && div_rsp.done) begin
      avg_r <= avg_neg_r ? RSSI_W'(-quo8) : quo8;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit_load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_data_r.channel_number     <= idx_r;
      out_data_r.ap_count           <= count_r[idx_r];
      out_data_r.strongest_rssi     <= strongest_r[idx_r];
      out_data_r.average_rssi       <= avg_r;
      out_data_r.interference_score <= score_r[idx_r];
      out_data_r.best_channel       <= best_ch_r;
      out_data_r.overflow           <= dropped_r;
      out_data_r.last               <= idx_r == LAST_CH;
    end
  end

  assign in_stall  = state_r != ST_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/wcia_checker.sv =====
// wcia_checker: port-level checks on the analyzer's report rows, bound to the top level
// depends on wcia_pkg and on the ports of wifi_channel_interference_analyzer_top
module wcia_checker #(
  parameter int NUM_CHANNELS = wcia_pkg::NUM_CHANNELS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input wcia_pkg::out_item_t out_data
);
  import wcia_pkg::*;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS);

  // a stalled row holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("report row changed while stalled");

  // the last flag marks the highest channel only
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.channel_number == LAST_CH)))
    else $error("last flag does not match the highest channel");

  // no new transaction is taken while a scan report is still being walked
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("input taken in the middle of a report");

  // empty channels report the floor average
  a_empty_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ap_count == '0 |-> out_data.average_rssi == FLOOR_RSSI)
    else $error("empty channel average is not the floor");

  // recommendation is a real channel
  a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.best_channel != '0 && out_data.best_channel <= LAST_CH)
    else $error("best channel out of range");

endmodule

bind wifi_channel_interference_analyzer_top wcia_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_wcia_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
